### rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants of the RGB Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

   localparam int unsigned SizeWidth = 11;
   localparam int unsigned PixWidth  = 24;
   localparam int unsigned SumWidth  = 17;
   localparam int unsigned RootSteps = 9;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       frame_end;
   } rsp_type;

   // One digit-pair step of the restoring square root, handed down the chain.
   // The partial root is kept scaled by the current trial bit, so it needs
   // the full width of the remainder.
   typedef struct packed {
      logic                valid;
      logic                last;
      logic [2:0][17:0]    rem;
      logic [2:0][17:0]    root;
   } root_stage_type;

endpackage

### rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram
// Generic simple dual-port RAM with registered read; a read of the address
// written at the same edge returns the old data.
// ----------------------------------------------------------------------------
module sem_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/sem_root_cell.sv
// ----------------------------------------------------------------------------
// sem_root_cell
// One cell of the square root chain: resolves one root bit for three channels.
// ----------------------------------------------------------------------------
module sem_root_cell import sem_pkg::*; #(
   parameter int unsigned STEP = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  root_stage_type prev,
   output root_stage_type next
);
   localparam int unsigned Shift = 2 * (RootSteps - 1 - STEP);
   root_stage_type next_in;
   root_stage_type next_ff;

   always_comb begin
      logic [17:0] bitv;
      logic [17:0] trial;
      next_in = prev;
      bitv    = 18'(1) << Shift;
      for (int ch = 0; ch < 3; ch++) begin
         trial = prev.root[ch] + bitv;
         if (prev.rem[ch] >= trial) begin
            next_in.rem[ch]  = prev.rem[ch] - trial;
            next_in.root[ch] = (prev.root[ch] >> 1) + bitv;
         end else begin
            next_in.root[ch] = prev.root[ch] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff.valid <= 1'b0;
      end else if (advance) begin
         next_ff.valid <= next_in.valid;
      end
      if (advance) begin
         next_ff.last <= next_in.last;
         next_ff.rem  <= next_in.rem;
         next_ff.root <= next_in.root;
      end
   end

   assign next = next_ff;
endmodule

### rtl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Streaming 3x3 Sobel edge magnitude on RGB pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one transfer per clock when the output side
// keeps up. The result for a pixel appears after frame_width+1 further items,
// so send frame_width+1 padding items after each frame. Each item passes a
// front stage (line store read), a gradient stage (window shift, sums), nine
// square root cells, one result bit per cell, and the output register; the
// sustained rate is one item per cycle. The whole pipeline stalls only when
// the output register holds a result that is not taken. The line stores are
// dual-port RAMs: the middle store is read and written at the current column
// on each transfer, the upper store is read then and written when stage 1
// advances, with the middle value that came out, and a transfer reading the
// column being written (one pixel wide frames) takes that value from a bypass.
// Their unwritten entries only feed taps masked off at the frame border. Sums
// of squares above 255.5^2 are clamped before the root, since they saturate.
module sobel_edge_magnitude_rgb import sem_pkg::*; #(
   parameter int unsigned MAX_WIDTH  = 1024,
   parameter int unsigned MAX_HEIGHT = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [0:0]           csr_index,
   input  logic [SizeWidth-1:0] csr_data
);
   localparam int unsigned AddrW = $clog2(MAX_WIDTH);
   localparam int unsigned ColW  = $clog2(MAX_WIDTH + 1);
   localparam int unsigned RowW  = $clog2(MAX_HEIGHT + 3);
   localparam int unsigned SzW   = ColW > RowW ? ColW : RowW;

   logic [SizeWidth-1:0] width_ff, height_ff;
   logic [ColW-1:0] w_eff;
   logic [RowW-1:0] h_eff;
   logic [ColW-1:0] col_ff, col_in;
   logic [RowW-1:0] row_ff, row_in;
   logic [RowW-1:0] pr;
   logic [ColW-1:0] pc;
   logic have, emit, last;
   logic advance, take;
   logic [PixWidth-1:0] pix, top, mid;
   logic [PixWidth-1:0] top_ram, mid_ram;
   logic [PixWidth-1:0] top_fwd_data_ff;
   logic top_fwd_ff;
   logic upper_we;
   logic [8:0] use_ff;
   logic s1_valid_ff, s1_last_ff;
   logic [PixWidth-1:0] s1_pix_ff;
   logic [AddrW-1:0] s1_addr_ff;
   logic s2_valid_ff, s2_last_ff;
   logic [2:0][17:0] s2_sum_ff;
   logic [2:0][PixWidth-1:0] w0_ff, w1_ff;
   logic [AddrW-1:0] addr;
   root_stage_type chain [RootSteps+1];
   logic out_valid_ff;
   rsp_type out_ff;

   always_comb begin
      if (width_ff == '0) w_eff = ColW'(1);
      else if (32'(width_ff) > MAX_WIDTH) w_eff = ColW'(MAX_WIDTH);
      else w_eff = ColW'(width_ff);
      if (height_ff == '0) h_eff = RowW'(1);
      else if (32'(height_ff) > MAX_HEIGHT) h_eff = RowW'(MAX_HEIGHT);
      else h_eff = RowW'(height_ff);
   end

   // Stall everything while a result waits in the output register.
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign take      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign pix  = req_data.kind ? '0 : {req_data.red_in, req_data.green_in, req_data.blue_in};
   assign addr = (32'(col_ff) < MAX_WIDTH) ? AddrW'(col_ff) : AddrW'(MAX_WIDTH - 1);

   // Upper store: write back the middle value once it has been read out.
   assign upper_we = advance && s1_valid_ff;

   sem_ram #(.WIDTH(PixWidth), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .wr_en(upper_we), .wr_addr(s1_addr_ff), .wr_data(mid),
      .rd_en(take), .rd_addr(addr), .rd_data(top_ram));
   assign top = top_fwd_ff ? top_fwd_data_ff : top_ram;

   sem_ram #(.WIDTH(PixWidth), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .wr_en(take), .wr_addr(addr), .wr_data(pix),
      .rd_en(take), .rd_addr(addr), .rd_data(mid_ram));
   assign mid = mid_ram;

   // Position logic and result decision at input time.
   always_comb begin
      have = 1'b0; pr = '0; pc = '0;
      if (col_ff >= ColW'(1) && row_ff >= RowW'(1)) begin
         have = 1'b1; pr = row_ff - RowW'(1); pc = col_ff - ColW'(1);
      end else if (col_ff == '0 && row_ff >= RowW'(2)) begin
         have = 1'b1; pr = row_ff - RowW'(2); pc = w_eff - ColW'(1);
      end
      emit = have && (pr < h_eff);
      last = emit && (pr == h_eff - RowW'(1)) && (pc == w_eff - ColW'(1));
      col_in = col_ff + ColW'(1);
      row_in = row_ff;
      if (col_in >= w_eff) begin
         col_in = '0; row_in = row_ff + RowW'(1);
      end
      if (last || SzW'(row_in) > SzW'(h_eff) + SzW'(1)) begin
         col_in = '0; row_in = '0;
      end
   end

   // Stage 1: hold pixel while the line stores read; use mask computed now.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0; row_ff <= '0; s1_valid_ff <= 1'b0;
         width_ff <= SizeWidth'(640); height_ff <= SizeWidth'(480);
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_FRAME_WIDTH) width_ff <= csr_data;
            else height_ff <= csr_data;
         end
         if (advance) s1_valid_ff <= take;
         if (take) begin
            col_ff <= col_in; row_ff <= row_in;
         end
      end
   end

   logic s1_emit_ff;
   always_ff @(posedge clock) begin
      if (take) begin
         s1_pix_ff  <= pix;
         s1_addr_ff <= addr;
         s1_emit_ff <= emit;
         s1_last_ff <= last;
         // Same column as the pending upper write: the RAM returns old data.
         top_fwd_ff      <= upper_we && (s1_addr_ff == addr);
         top_fwd_data_ff <= mid;
         for (int rr = 0; rr < 3; rr++) begin
            for (int cc = 0; cc < 3; cc++) begin
               use_ff[rr*3+cc] <= ((rr == 0) ? (pr >= RowW'(1)) :
                                   (rr == 2) ? (SzW'(pr) + SzW'(1) < SzW'(h_eff)) : 1'b1) &&
                                  ((cc == 0) ? (pc >= ColW'(1)) :
                                   (cc == 2) ? (pc + ColW'(1) < w_eff) : 1'b1);
            end
         end
      end
   end

   // Stage 2: shift window (columns held in w0/w1), form gradients.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         w0_ff <= '0; w1_ff <= '0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         if (s1_valid_ff) begin
            w0_ff <= w1_ff;
            w1_ff <= {s1_pix_ff, mid, top};
         end
      end
   end

   // Index 0 of the sums is blue, index 2 red, as in the packed pixel.
   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         s2_last_ff <= s1_last_ff;
         for (int ch = 0; ch < 3; ch++) begin
            logic signed [11:0] gx, gy;
            logic signed [11:0] v [9];
            logic signed [21:0] gx2, gy2;
            logic [21:0] s;
            for (int rr = 0; rr < 3; rr++) begin
               v[rr*3+0] = use_ff[rr*3+0] ? 12'(w0_ff[rr][ch*8 +: 8]) : '0;
               v[rr*3+1] = use_ff[rr*3+1] ? 12'(w1_ff[rr][ch*8 +: 8]) : '0;
            end
            v[2] = use_ff[2] ? 12'(top[ch*8 +: 8]) : '0;
            v[5] = use_ff[5] ? 12'(mid[ch*8 +: 8]) : '0;
            v[8] = use_ff[8] ? 12'(s1_pix_ff[ch*8 +: 8]) : '0;
            gx = v[2] - v[0] + 12'(2) * (v[5] - v[3]) + v[8] - v[6];
            gy = v[6] - v[0] + 12'(2) * (v[7] - v[1]) + v[8] - v[2];
            gx2 = 22'(gx) * 22'(gx);
            gy2 = 22'(gy) * 22'(gy);
            s   = gx2 + gy2;
            // Anything above 255*255+255 rounds to 256 or more: clamp it.
            s2_sum_ff[ch] <= (s > 22'(65280)) ? 18'(65281) : 18'(s);
         end
      end
   end

   always_comb begin
      chain[0].valid = s2_valid_ff;
      chain[0].last  = s2_last_ff;
      chain[0].rem   = s2_sum_ff;
      chain[0].root  = '0;
   end

   for (genvar g = 0; g < RootSteps; g++) begin : g_root
      sem_root_cell #(.STEP(g)) u_cell (
         .clock(clock), .reset(reset), .advance(advance),
         .prev(chain[g]), .next(chain[g+1]));
   end

   // Output register: round to nearest and saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= chain[RootSteps].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         logic [9:0] k [3];
         for (int ch = 0; ch < 3; ch++) begin
            k[ch] = 10'(chain[RootSteps].root[ch]);
            if (chain[RootSteps].rem[ch] > 18'(k[ch])) k[ch] = k[ch] + 10'(1);
            if (k[ch] > 10'(255)) k[ch] = 10'(255);
         end
         out_ff.red_out   <= k[2][7:0];
         out_ff.green_out <= k[1][7:0];
         out_ff.blue_out  <= k[0][7:0];
         out_ff.frame_end <= chain[RootSteps].last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
endmodule
